// ===== src/fat12rds_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT12 root directory search: shared definitions
// Types, register indexes, directory entry offsets and the character
// folding function used by the search block.
// ----------------------------------------------------------------------------
package fat12rds_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned CLUSTER_W  = 16;
    localparam int unsigned SIZE_W     = 32;
    localparam int unsigned BASE_W     = 64;
    localparam int unsigned EXT_W      = 24;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 1;

    // Directory entry layout
    localparam logic [POS_W-1:0] POS_FIRST      = 5'd0;
    localparam logic [POS_W-1:0] POS_ATTR       = 5'd11;
    localparam logic [POS_W-1:0] POS_CLUSTER_LO = 5'd26;
    localparam logic [POS_W-1:0] POS_CLUSTER_HI = 5'd27;
    localparam logic [POS_W-1:0] POS_SIZE       = 5'd28;
    localparam logic [POS_W-1:0] POS_LAST       = 5'd31;

    localparam logic [BYTE_W-1:0] END_MARK          = 8'h00;
    localparam logic [BYTE_W-1:0] DELETED_MARK      = 8'hE5;
    localparam logic [BYTE_W-1:0] ATTR_VOLUME_LABEL = 8'h08;

    localparam logic [BASE_W-1:0] NAME_BASE_RESET      = 64'h2020202020202020;
    localparam logic [EXT_W-1:0]  NAME_EXTENSION_RESET = 24'h202020;

    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NAME_BASE      = 1'b0,
        REG_NAME_EXTENSION = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] dir_byte;
        logic              search_start;
        logic              region_end;
    } item_t;

    typedef struct packed {
        logic                 search_status;
        logic [CLUSTER_W-1:0] start_cluster;
        logic [SIZE_W-1:0]    file_size;
    } result_t;

    // Only the letters a to z are folded to upper case.
    function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== src/fat12rds_core.sv =====
// ----------------------------------------------------------------------------
// FAT12 root directory search: entry scanner
// Holds the search progress and works through one directory byte per
// advance, producing at most one result.
// ----------------------------------------------------------------------------
module fat12rds_core
    import fat12rds_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  item_t             item,
    input  logic [BASE_W-1:0] name_base,
    input  logic [EXT_W-1:0]  name_extension,
    output logic              res_valid,
    output result_t           res
);

    logic [POS_W-1:0]          pos_reg, pos_next, pos_cur;
    logic                      skip_reg, skip_next, skip_cur;
    logic                      mismatch_reg, mismatch_next, mismatch_cur;
    logic                      done_reg, done_next, done_cur;
    logic [1:0][BYTE_W-1:0]    cluster_reg, cluster_next, cluster_cur;
    logic [3:0][BYTE_W-1:0]    size_reg, size_next, size_cur;
    logic [15:0][BYTE_W-1:0]   name_bytes;
    logic [BYTE_W-1:0]         b;

    // Name characters by entry offset; offsets past the name are never compared.
    assign name_bytes = {40'd0, name_extension, name_base};
    assign b          = item.dir_byte;

    always_comb begin
        // A new search clears all progress before the byte is handled.
        pos_cur      = item.search_start ? '0 : pos_reg;
        skip_cur     = item.search_start ? 1'b0 : skip_reg;
        mismatch_cur = item.search_start ? 1'b0 : mismatch_reg;
        done_cur     = item.search_start ? 1'b0 : done_reg;
        cluster_cur  = item.search_start ? '0 : cluster_reg;
        size_cur     = item.search_start ? '0 : size_reg;

        pos_next      = pos_cur;
        skip_next     = skip_cur;
        mismatch_next = mismatch_cur;
        done_next     = done_cur;
        cluster_next  = cluster_cur;
        size_next     = size_cur;

        res_valid         = 1'b0;
        res.search_status = STATUS_NOT_FOUND;
        res.start_cluster = '0;
        res.file_size     = '0;

        if (!done_cur) begin
            if (pos_cur == POS_FIRST) begin
                skip_next     = 1'b0;
                mismatch_next = 1'b0;
            end
            if (pos_cur == POS_FIRST && b == END_MARK) begin
                done_next = 1'b1;
                res_valid = 1'b1;
            end else begin
                if (pos_cur == POS_FIRST && b == DELETED_MARK) begin
                    skip_next = 1'b1;
                end
                if (pos_cur < POS_ATTR) begin
                    if (upcase(b) != upcase(name_bytes[pos_cur[3:0]])) begin
                        mismatch_next = 1'b1;
                    end
                end else if (pos_cur == POS_ATTR) begin
                    if ((b & ATTR_VOLUME_LABEL) != '0) begin
                        skip_next = 1'b1;
                    end
                end else if (pos_cur == POS_CLUSTER_LO || pos_cur == POS_CLUSTER_HI) begin
                    cluster_next[pos_cur[0]] = b;
                end else if (pos_cur >= POS_SIZE) begin
                    size_next[pos_cur[1:0]] = b;
                end
                pos_next = pos_cur + 1'b1;

                if (pos_cur == POS_LAST && !skip_next && !mismatch_next) begin
                    done_next         = 1'b1;
                    res_valid         = 1'b1;
                    res.search_status = STATUS_FOUND;
                    res.start_cluster = cluster_next;
                    res.file_size     = size_next;
                end else if (item.region_end) begin
                    done_next = 1'b1;
                    res_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            skip_reg     <= 1'b0;
            mismatch_reg <= 1'b0;
            done_reg     <= 1'b0;
            cluster_reg  <= '0;
            size_reg     <= '0;
        end else if (advance) begin
            pos_reg      <= pos_next;
            skip_reg     <= skip_next;
            mismatch_reg <= mismatch_next;
            done_reg     <= done_next;
            cluster_reg  <= cluster_next;
            size_reg     <= size_next;
        end
    end

endmodule

// ===== src/fat12_root_directory_search.sv =====
// ----------------------------------------------------------------------------
// FAT12 root directory search
// Scans a FAT12 root directory byte stream for a configured 8.3 name.
// ----------------------------------------------------------------------------
// Usage:
// Directory bytes arrive on the s_ channel (valid/ready), one item per byte,
// together with a search start flag on the first byte of a search and a
// region end flag on the final byte of the directory region. Each 32-byte
// entry's name is compared, case-folded, with the name held in the
// configuration registers, written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the block is idle; the block does not enforce this.
// At most one result item leaves on the m_ channel per search: either the
// found status with the start cluster and file size, or the not-found status
// with zero fields. Bytes after the end of a search are consumed silently
// until the next search start.
// The block accepts one byte per cycle unless the input register is full and
// cannot move on. An accepted byte is worked on in the input register; its
// result is loaded into the result register, which drives m_valid, once that
// register is free or being emptied. While a result waits, the input register
// can still take one byte; once it is full, input ready drops and nothing is lost.
// Reset clears the search progress, empties both registers and restores the
// configured name to eleven spaces.
// ----------------------------------------------------------------------------
module fat12_root_directory_search
    import fat12rds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Directory byte input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_dir_byte,
    input  logic                  s_search_start,
    input  logic                  s_region_end,
    // Search result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_search_status,
    output logic [CLUSTER_W-1:0]  m_start_cluster,
    output logic [SIZE_W-1:0]     m_file_size
);

    logic [BASE_W-1:0] name_base_reg;
    logic [EXT_W-1:0]  name_extension_reg;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;

    logic    advance;
    logic    core_res_valid;
    result_t core_res;

    // The held byte moves on whenever the result register is free or is
    // being emptied in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_base_reg      <= NAME_BASE_RESET;
            name_extension_reg <= NAME_EXTENSION_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_NAME_BASE:      name_base_reg      <= cfg_data[BASE_W-1:0];
                REG_NAME_EXTENSION: name_extension_reg <= cfg_data[EXT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.dir_byte     <= s_dir_byte;
            in_item_reg.search_start <= s_search_start;
            in_item_reg.region_end   <= s_region_end;
        end
    end

    fat12rds_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .item           (in_item_reg),
        .name_base      (name_base_reg),
        .name_extension (name_extension_reg),
        .res_valid      (core_res_valid),
        .res            (core_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= core_res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && core_res_valid) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_search_status = out_res_reg.search_status;
    assign m_start_cluster = out_res_reg.start_cluster;
    assign m_file_size     = out_res_reg.file_size;

endmodule

// ===== src/fat12rds_checker.sv =====
// ----------------------------------------------------------------------------
// FAT12 root directory search: port checker
// Watches the ports of the search block over time and is bound to it.
// ----------------------------------------------------------------------------
module fat12rds_checker
    import fat12rds_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_search_status,
    input logic [CLUSTER_W-1:0] m_start_cluster,
    input logic [SIZE_W-1:0]    m_file_size
);

    // The output register is empty straight after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_search_status)
            && $stable(m_start_cluster) && $stable(m_file_size))
        else $error("stalled result changed");

    // A not-found result carries no cluster and no size.
    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_search_status == STATUS_NOT_FOUND
            |-> m_start_cluster == '0 && m_file_size == '0)
        else $error("not-found result with non-zero fields");

    // A fresh result follows an accepted byte, by way of the input register.
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching accepted byte");

endmodule

bind fat12_root_directory_search fat12rds_checker u_fat12rds_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_search_status (m_search_status),
    .m_start_cluster (m_start_cluster),
    .m_file_size     (m_file_size)
);

// ===== tb/fat12_root_directory_search_test.sv =====
// ----------------------------------------------------------------------------
// FAT12 root directory search: block-level test
// Streams directory bytes through the search block and checks each search
// result against a predictor that runs alongside the stimulus. The run starts
// with a few hand-picked bytes under the reset name. It then goes through
// several configured names, the all-zero and all-ones names among them. Under
// each name it sends randomised searches: matching, deleted, volume-label and
// near-miss entries, end markers, early region ends and abandoned searches.
// Both handshakes stall in random bursts.
// ----------------------------------------------------------------------------
module fat12_root_directory_search_test;
    import fat12rds_pkg::*;

    localparam int ENTRY_BYTES   = 32;
    localparam int NAME_BYTES    = 11;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 115;
    localparam int QUIET_LIMIT   = 400;
    localparam int SETTLE_CYCLES = 8;

    // Kinds of 32-byte entry that the generator can lay down.
    typedef enum int {
        ENTRY_TARGET,
        ENTRY_NEAR_MISS,
        ENTRY_DELETED,
        ENTRY_VOLUME,
        ENTRY_NOISE
    } entry_kind_t;

    // Ways in which a generated search can finish.
    typedef enum int {
        END_ON_TARGET,
        END_ON_TARGET_AT_REGION_END,
        END_ON_MARKER,
        END_CUT_SHORT,
        END_AT_REGION_END,
        END_ABANDONED,
        END_SCRAMBLED
    } search_end_t;

    // ------------------------------------------------------------------------
    // Predictor and result checker. It keeps its own copy of the name
    // registers and of the scan progress, works out the result (if any) of
    // each accepted byte and compares it with what leaves the block.
    // ------------------------------------------------------------------------
    class directory_lookup_sb;
        logic [BASE_W-1:0]    want_base;
        logic [EXT_W-1:0]     want_ext;
        logic [POS_W-1:0]     offset;
        logic                 skipped;
        logic                 mismatch;
        logic                 done;
        logic [CLUSTER_W-1:0] cluster_acc;
        logic [SIZE_W-1:0]    size_acc;
        result_t              awaited[$];
        int                   failures;
        int                   predicted;
        int                   n_found;
        int                   n_missing;

        function new();
            want_base = NAME_BASE_RESET;
            want_ext  = NAME_EXTENSION_RESET;
            failures  = 0;
            predicted = 0;
            n_found   = 0;
            n_missing = 0;
            restart();
        endfunction

        function void restart();
            offset      = '0;
            skipped     = 1'b0;
            mismatch    = 1'b0;
            done        = 1'b0;
            cluster_acc = '0;
            size_acc    = '0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_NAME_BASE: begin
                    want_base = data[BASE_W-1:0];
                end
                REG_NAME_EXTENSION: begin
                    want_ext = data[EXT_W-1:0];
                end
                default: ;
            endcase
        endfunction

        function logic [BYTE_W-1:0] fold_case(logic [BYTE_W-1:0] c);
            return (c inside {[8'h61:8'h7A]}) ? (c & 8'hDF) : c;
        endfunction

        function logic [BYTE_W-1:0] name_char(logic [POS_W-1:0] p);
            if (p < 8) begin
                return want_base[8*p +: 8];
            end
            return want_ext[8*(p-8) +: 8];
        endfunction

        function void push(logic status, logic [CLUSTER_W-1:0] cl, logic [SIZE_W-1:0] sz);
            result_t r;
            r.search_status = status;
            r.start_cluster = cl;
            r.file_size     = sz;
            awaited.push_back(r);
            predicted++;
            done = 1'b1;
        endfunction

        // Called for every byte that the block accepts.
        function void take_byte(item_t it);
            logic [BYTE_W-1:0] b;
            logic [POS_W-1:0]  p;
            int                sh;
            b = it.dir_byte;
            if (it.search_start) begin
                restart();
            end
            if (done) begin
                return;
            end
            p = offset;
            if (p == POS_FIRST) begin
                skipped  = 1'b0;
                mismatch = 1'b0;
                if (b == END_MARK) begin
                    push(STATUS_NOT_FOUND, '0, '0);
                    return;
                end
                if (b == DELETED_MARK) begin
                    skipped = 1'b1;
                end
            end
            if (p < POS_ATTR) begin
                if (fold_case(b) != fold_case(name_char(p))) begin
                    mismatch = 1'b1;
                end
            end else if (p == POS_ATTR) begin
                if ((b & ATTR_VOLUME_LABEL) != 0) begin
                    skipped = 1'b1;
                end
            end else if (p == POS_CLUSTER_LO) begin
                cluster_acc[7:0] = b;
            end else if (p == POS_CLUSTER_HI) begin
                cluster_acc[15:8] = b;
            end else if (p >= POS_SIZE) begin
                sh = 8 * (int'(p) - int'(POS_SIZE));
                size_acc[sh +: 8] = b;
            end
            offset = p + 1'b1;
            if (p == POS_LAST && !skipped && !mismatch) begin
                push(STATUS_FOUND, cluster_acc, size_acc);
                return;
            end
            if (it.region_end) begin
                push(STATUS_NOT_FOUND, '0, '0);
            end
        endfunction

        // Called for every result that the block hands over.
        function void take_result(result_t got);
            result_t want;
            if (awaited.size() == 0) begin
                failures++;
                $display("%0t: result with nothing expected: status=%0b cluster=%h size=%h",
                         $time, got.search_status, got.start_cluster, got.file_size);
                return;
            end
            want = awaited.pop_front();
            if (got.search_status !== want.search_status) begin
                failures++;
                $display("%0t: search_status expected %0b, got %0b",
                         $time, want.search_status, got.search_status);
            end
            if (got.start_cluster !== want.start_cluster) begin
                failures++;
                $display("%0t: start_cluster expected %h, got %h",
                         $time, want.start_cluster, got.start_cluster);
            end
            if (got.file_size !== want.file_size) begin
                failures++;
                $display("%0t: file_size expected %h, got %h",
                         $time, want.file_size, got.file_size);
            end
            if (want.search_status == STATUS_FOUND) begin
                n_found++;
            end else begin
                n_missing++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void close();
            if (awaited.size() != 0) begin
                failures += awaited.size();
                $display("%0t: %0d expected results never arrived", $time, awaited.size());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its stimulus signals. Every input has a known
    // value from time zero.
    // ------------------------------------------------------------------------
    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = REG_NAME_BASE;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_dir_byte      = '0;
    logic                  s_search_start  = 1'b0;
    logic                  s_region_end    = 1'b0;
    logic                  m_valid;
    logic                  m_ready         = 1'b1;
    logic                  m_search_status;
    logic [CLUSTER_W-1:0]  m_start_cluster;
    logic [SIZE_W-1:0]     m_file_size;

    fat12_root_directory_search i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_dir_byte      (s_dir_byte),
        .s_search_start  (s_search_start),
        .s_region_end    (s_region_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_search_status (m_search_status),
        .m_start_cluster (m_start_cluster),
        .m_file_size     (m_file_size)
    );

    directory_lookup_sb sb = new();

    // The name that the block currently holds, used to build entries.
    logic [BASE_W-1:0] cur_base = NAME_BASE_RESET;
    logic [EXT_W-1:0]  cur_ext  = NAME_EXTENSION_RESET;

    // Odds of a stall burst per cycle on each side; zero means no stalls.
    int tx_odds = 0;
    int rx_odds = 0;

    int bytes_sent    = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Receiver: holds m_ready low in random bursts. Changes are made at the
    // falling edge so that the block sees them settled.
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_odds != 0 && $urandom_range(0, rx_odds - 1) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
                m_ready = 1'b1;
            end
        end
    end

    // Every result handed over is checked at the rising edge on which it is
    // accepted.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.take_result('{search_status: m_search_status,
                             start_cluster: m_start_cluster,
                             file_size:     m_file_size});
        end
    end

    // Watchdog: a long run of cycles without any handshake means the block
    // has hung, so the run is ended.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: watchdog expired, no handshake for %0d cycles",
                         $time, quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. The item is put on the bus at a falling edge and held until a
    // rising edge sees valid and ready together; only then does the predictor
    // learn of it. Valid is left high between back-to-back items and is only
    // lowered when a stall burst or a pause follows.
    // ------------------------------------------------------------------------
    task automatic send_item(item_t it);
        @(negedge aclk);
        if (tx_odds != 0 && $urandom_range(0, tx_odds - 1) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_dir_byte     = it.dir_byte;
        s_search_start = it.search_start;
        s_region_end   = it.region_end;
        s_valid        = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.take_byte(it);
        bytes_sent++;
    endtask

    task automatic put_byte(logic [BYTE_W-1:0] b, logic start, logic last);
        send_item('{dir_byte: b, search_start: start, region_end: last});
    endtask

    // Stop sending and wait until every predicted result has been taken,
    // then give the pipeline time to swallow any bytes that cause nothing.
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both name registers are written on consecutive cycles. The extension
    // write carries random upper bits, which the block must drop.
    task automatic write_name(logic [BASE_W-1:0] base, logic [EXT_W-1:0] ext);
        logic [CFG_DATA_W-1:0] ext_word;
        ext_word = {$urandom(), $urandom()};
        ext_word[EXT_W-1:0] = ext;
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = REG_NAME_BASE;
        cfg_data  = base;
        @(negedge aclk);
        cfg_index = REG_NAME_EXTENSION;
        cfg_data  = ext_word;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.write_reg(REG_NAME_BASE, base);
        sb.write_reg(REG_NAME_EXTENSION, ext_word);
        cur_base = base;
        cur_ext  = ext;
        settings_used++;
    endtask

    function automatic bit is_letter(logic [BYTE_W-1:0] c);
        return ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A);
    endfunction

    // One character for a configured name: mostly the printable set that a
    // real 8.3 name uses, sometimes lower case, now and then any byte at all.
    function automatic logic [BYTE_W-1:0] pick_name_char(bit lower_only);
        int r;
        r = $urandom_range(0, 9);
        if (lower_only) begin
            return 8'($urandom_range(8'h61, 8'h7A));
        end
        case (r)
            0, 1, 2: return 8'($urandom_range(8'h41, 8'h5A));
            3, 4:    return 8'($urandom_range(8'h61, 8'h7A));
            5:       return 8'($urandom_range(8'h30, 8'h39));
            6, 7:    return 8'h20;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Appends up to one directory entry to a search. Entries other than the
    // noise kind start from the configured name, with letters flipped in case
    // at random so that the case folding on both sides is exercised. The
    // cluster and size fields are sometimes forced to all zeros or all ones.
    // ------------------------------------------------------------------------
    task automatic add_entry(entry_kind_t kind, int count, bit end_on_last,
                             ref item_t seq[$]);
        logic [BYTE_W-1:0] ent [ENTRY_BYTES];
        logic [BYTE_W-1:0] c;
        item_t             it;
        int                r;
        for (int i = 0; i < ENTRY_BYTES; i++) begin
            ent[i] = 8'($urandom);
        end
        if (kind != ENTRY_NOISE) begin
            for (int i = 0; i < NAME_BYTES; i++) begin
                c = (i < 8) ? cur_base[8*i +: 8] : cur_ext[8*(i-8) +: 8];
                if (is_letter(c) && $urandom_range(0, 1) == 1) begin
                    c = c ^ 8'h20;
                end
                ent[i] = c;
            end
            ent[POS_ATTR] = ent[POS_ATTR] & ~ATTR_VOLUME_LABEL;
        end
        case (kind)
            ENTRY_NEAR_MISS: ent[$urandom_range(0, NAME_BYTES - 1)] = 8'($urandom);
            ENTRY_DELETED:   ent[POS_FIRST] = DELETED_MARK;
            ENTRY_VOLUME:    ent[POS_ATTR] = ent[POS_ATTR] | ATTR_VOLUME_LABEL;
            default: ;
        endcase
        r = $urandom_range(0, 5);
        for (int i = POS_CLUSTER_LO; i < ENTRY_BYTES; i++) begin
            if (r == 0) begin
                ent[i] = 8'hFF;
            end else if (r == 1) begin
                ent[i] = 8'h00;
            end
        end
        for (int i = 0; i < count; i++) begin
            it.dir_byte     = ent[i];
            it.search_start = 1'b0;
            it.region_end   = end_on_last && (i == count - 1);
            seq.push_back(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // One search: up to three entries that should not match, then an ending
    // chosen at random. A few bytes carry stray region ends or are replaced
    // by noise, and a few trailing bytes follow, which the block ignores once
    // the search is over.
    // ------------------------------------------------------------------------
    task automatic run_search(output int counted);
        item_t       seq[$];
        item_t       it;
        search_end_t ending;
        int          n_before;
        n_before = $urandom_range(0, 3);
        ending   = search_end_t'($urandom_range(0, 9) % 7);
        for (int e = 0; e < n_before; e++) begin
            add_entry(entry_kind_t'($urandom_range(ENTRY_NEAR_MISS, ENTRY_NOISE)),
                      ENTRY_BYTES, 1'b0, seq);
        end
        case (ending)
            END_ON_TARGET: begin
                add_entry(ENTRY_TARGET, ENTRY_BYTES, 1'b0, seq);
            end
            END_ON_TARGET_AT_REGION_END: begin
                // The found result must win over the region end.
                add_entry(ENTRY_TARGET, ENTRY_BYTES, 1'b1, seq);
            end
            END_ON_MARKER: begin
                it = '{dir_byte: END_MARK, search_start: 1'b0, region_end: 1'b0};
                seq.push_back(it);
            end
            END_CUT_SHORT: begin
                add_entry(ENTRY_TARGET, $urandom_range(1, ENTRY_BYTES - 1), 1'b1, seq);
            end
            END_AT_REGION_END: begin
                add_entry(ENTRY_NEAR_MISS, ENTRY_BYTES, 1'b1, seq);
            end
            END_ABANDONED: begin
                // No end at all: the next search start cuts this one off.
                add_entry(ENTRY_TARGET, $urandom_range(1, ENTRY_BYTES - 1), 1'b0, seq);
            end
            default: begin
                add_entry(ENTRY_NOISE, ENTRY_BYTES, $urandom_range(0, 1) == 1, seq);
            end
        endcase
        for (int i = 1; i < seq.size(); i++) begin
            if ($urandom_range(0, 79) == 0) begin
                seq[i].region_end = 1'b1;
            end
            if ($urandom_range(0, 149) == 0) begin
                seq[i].dir_byte = 8'($urandom);
            end
        end
        seq[0].search_start = 1'b1;
        counted = seq.size();
        repeat ($urandom_range(0, 3)) begin
            it = '{dir_byte: 8'($urandom), search_start: 1'b0, region_end: 1'b0};
            seq.push_back(it);
        end
        foreach (seq[i]) begin
            send_item(seq[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [BASE_W-1:0] base;
        logic [EXT_W-1:0]  ext;
        int                phase_bytes;
        int                n;
        int                searches;

        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed bytes under the reset name of eleven spaces. The first
        // two arrive before any search start and belong to the search that
        // reset begins.
        put_byte(8'h20, 1'b0, 1'b0);
        put_byte(8'h61, 1'b0, 1'b0);
        // An end marker on a fresh search, then a byte that must be ignored.
        put_byte(END_MARK, 1'b1, 1'b0);
        put_byte(8'hFF, 1'b0, 1'b0);
        // A deleted entry cut short by the region end.
        put_byte(DELETED_MARK, 1'b1, 1'b0);
        put_byte(8'h7A, 1'b0, 1'b1);
        // End marker and region end on the same byte give one result only.
        put_byte(END_MARK, 1'b1, 1'b1);
        // A search restarted part way through an entry, with a zero name
        // byte after the first that is compared as an ordinary character.
        put_byte(8'h41, 1'b1, 1'b0);
        put_byte(8'hFF, 1'b1, 1'b0);
        put_byte(8'h00, 1'b0, 1'b0);
        put_byte(8'h80, 1'b0, 1'b1);
        // An entry that starts with a space under the all-space name.
        put_byte(8'h20, 1'b1, 1'b0);
        put_byte(8'h5B, 1'b0, 1'b0);
        put_byte(8'h60, 1'b0, 1'b1);
        drain_results();

        // Random phases, each under its own name and its own stall odds. The
        // second and third use the all-zero and all-ones names; the last runs
        // with no stalls at all.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 1) begin
                base = '0;
                ext  = '0;
            end else if (ph == 2) begin
                base = '1;
                ext  = '1;
            end else begin
                for (int i = 0; i < 8; i++) begin
                    base[8*i +: 8] = pick_name_char(ph == 3);
                end
                for (int i = 0; i < 3; i++) begin
                    ext[8*i +: 8] = pick_name_char(ph == 3);
                end
            end
            write_name(base, ext);
            if (ph == PHASES - 1) begin
                tx_odds = 0;
                rx_odds = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       tx_odds = 0;
                    1:       tx_odds = 3;
                    default: tx_odds = 12;
                endcase
                case ($urandom_range(0, 3))
                    0:       rx_odds = 0;
                    1:       rx_odds = 2;
                    default: rx_odds = 10;
                endcase
            end
            phase_bytes = 0;
            searches    = 0;
            while (phase_bytes < PHASE_ITEMS) begin
                run_search(n);
                phase_bytes += n;
                searches++;
                // Now and then the sender holds off until the receiver has
                // caught up with every outstanding result.
                if (searches % 5 == 4) begin
                    drain_results();
                end
            end
            drain_results();
        end
        rx_odds = 0;

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        sb.close();

        $display("Sent %0d directory bytes under %0d configured names plus the reset name.",
                 bytes_sent, settings_used);
        $display("Searches ended with the file found %0d times and not found %0d times.",
                 sb.n_found, sb.n_missing);
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
